@@ hw/rtl/gwws_pkg.sv @@
// ----------------------------------------------------------------------------
// gwws_pkg
// Shared types and constants for the greedy word wrap stream unit.
// ----------------------------------------------------------------------------
package gwws_pkg;

  localparam logic [7:0] SPACE_BYTE       = 8'h20;
  localparam logic [7:0] NEWLINE_BYTE     = 8'h0A;
  localparam logic [7:0] TAB_BYTE         = 8'h09;
  localparam logic [7:0] CR_BYTE          = 8'h0D;
  localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;

  // control word broadcast along the cell chain
  typedef struct packed {
    logic       wr;
    logic       shift;
    logic [7:0] wdata;
  } chain_ctl_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == SPACE_BYTE) || ((b >= TAB_BYTE) && (b <= CR_BYTE));
  endfunction

endpackage

@@ hw/rtl/gwws_cell.sv @@
// ----------------------------------------------------------------------------
// gwws_cell
// One byte cell of the word chain: loads when selected, shifts towards head.
// ----------------------------------------------------------------------------
module gwws_cell (
  input  logic                clk,
  input  gwws_pkg::chain_ctl_t ctl,
  input  logic                sel,
  input  logic [7:0]          shift_in,
  output logic [7:0]          q
);
  import gwws_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q <= shift_in;
    end else if (ctl.wr && sel) begin
      q <= ctl.wdata;
    end
  end

endmodule

@@ hw/rtl/gwws_chain.sv @@
// ----------------------------------------------------------------------------
// gwws_chain
// Row of byte cells holding the current word; the head cell feeds the output.
// ----------------------------------------------------------------------------
module gwws_chain #(
  parameter int WORD_MAX = 32,
  parameter int CW       = $clog2(WORD_MAX + 1)
) (
  input  logic                 clk,
  input  gwws_pkg::chain_ctl_t ctl,
  input  logic [CW-1:0]        wr_pos,
  output logic [7:0]           head
);
  import gwws_pkg::*;

  logic [7:0] q [WORD_MAX];

  for (genvar i = 0; i < WORD_MAX; i++) begin : g_cell
    logic [7:0] nb;
    logic       sel;
    if (i == WORD_MAX - 1) begin : g_tail
      assign nb = 8'h00;
    end else begin : g_mid
      assign nb = q[i+1];
    end
    assign sel = (wr_pos == CW'(i));
    gwws_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .sel      (sel),
      .shift_in (nb),
      .q        (q[i])
    );
  end

  assign head = q[0];

endmodule

@@ hw/rtl/greedy_word_wrap_stream_unit.sv @@
// ----------------------------------------------------------------------------
// greedy_word_wrap_stream_unit
// Greedy word wrap of a byte stream, one character or end marker per output word.
// ----------------------------------------------------------------------------
// Input channel: text_byte / end_of_text with in_valid, in_stall. Output
// channel: out_byte, is_char, word_truncated, text_done, run_last with
// out_valid, out_stall. A word moves when valid is high and stall is low.
// cfg_write loads cfg_data into the line width register (reset 80); write
// only while idle.
// A non-space byte is accepted and stored in the word chain; once the chain
// holds WORD_MAX bytes further ones are dropped and word_truncated is set.
// After a closing byte is accepted, the separator (if any), each word byte
// and the end marker (on end_of_text) are loaded into the output register
// in turn while it is free; the chain shifts one cell per word byte. On
// acceptance the state register moves to S_SEP, S_WORD or S_END, and the
// first result is then loaded into the output register. in_stall is high
// from acceptance of a closing byte until its last result is loaded there.
// Reset (rst, synchronous) clears counts, flags and out_valid; chain
// contents and output fields stay undefined until written. While out_stall
// is high with out_valid set, the output register holds and emission pauses.
// ----------------------------------------------------------------------------
module greedy_word_wrap_stream_unit #(
  parameter int WORD_MAX = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       is_char,
  output logic       word_truncated,
  output logic       text_done,
  output logic       run_last
);
  import gwws_pkg::*;

  localparam int CW = $clog2(WORD_MAX + 1);

  typedef enum logic [1:0] {S_IDLE, S_SEP, S_WORD, S_END} state_t;

  state_t        state;
  logic [7:0]    line_width;
  logic [CW-1:0] word_count;
  logic [7:0]    line_count;
  logic          word_overflowed;
  logic          pend_last;
  logic [7:0]    sep_byte;

  logic          accept, out_load, space, full;
  logic [CW-1:0] wc_eff;
  logic          ovf_eff;
  logic [9:0]    fit_sum;
  chain_ctl_t    ctl;
  logic [7:0]    head;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = !out_valid || !out_stall;
  assign space    = is_space(text_byte);
  assign full     = (word_count >= CW'(WORD_MAX));
  assign wc_eff   = (!space && !full) ? word_count + CW'(1) : word_count;
  assign ovf_eff  = word_overflowed || (!space && full);
  assign fit_sum  = {2'b00, line_count} + 10'd1 + 10'(wc_eff);

  assign ctl.wr    = accept && !space && !full;
  assign ctl.shift = (state == S_WORD) && out_load;
  assign ctl.wdata = text_byte;

  gwws_chain #(.WORD_MAX(WORD_MAX), .CW(CW)) u_chain (
    .clk    (clk),
    .ctl    (ctl),
    .wr_pos (word_count),
    .head   (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      line_width      <= LINE_WIDTH_RESET;
      word_count      <= '0;
      line_count      <= '0;
      word_overflowed <= 1'b0;
      pend_last       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        line_width <= cfg_data;
      end
      if (out_load) begin
        out_valid <= (state == S_SEP) || (state == S_WORD) || (state == S_END);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            word_count      <= wc_eff;
            word_overflowed <= ovf_eff;
            pend_last       <= end_of_text;
            if ((space || end_of_text) && (wc_eff != '0)) begin
              if (line_count == 8'd0) begin
                line_count <= 8'(wc_eff);
                state      <= S_WORD;
              end else if (fit_sum <= {2'b00, line_width}) begin
                line_count <= fit_sum[7:0];
                sep_byte   <= SPACE_BYTE;
                state      <= S_SEP;
              end else begin
                line_count <= 8'(wc_eff);
                sep_byte   <= NEWLINE_BYTE;
                state      <= S_SEP;
              end
            end else if (end_of_text) begin
              state <= S_END;
            end
          end
        end
        S_SEP: begin
          if (out_load) begin
            out_byte       <= sep_byte;
            is_char        <= 1'b1;
            word_truncated <= word_overflowed;
            text_done      <= 1'b0;
            run_last       <= 1'b0;
            state          <= S_WORD;
          end
        end
        S_WORD: begin
          if (out_load) begin
            out_byte       <= head;
            is_char        <= 1'b1;
            word_truncated <= word_overflowed;
            text_done      <= 1'b0;
            run_last       <= 1'b0;
            word_count     <= word_count - CW'(1);
            if (word_count == CW'(1)) begin
              run_last        <= !pend_last;
              word_overflowed <= 1'b0;
              state           <= pend_last ? S_END : S_IDLE;
            end
          end
        end
        S_END: begin
          if (out_load) begin
            out_byte        <= 8'h00;
            is_char         <= 1'b0;
            word_truncated  <= 1'b0;
            text_done       <= 1'b1;
            run_last        <= 1'b1;
            word_count      <= '0;
            line_count      <= '0;
            word_overflowed <= 1'b0;
            pend_last       <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_end_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_done |-> run_last && !is_char && (out_byte == 8'h00))
    else $error("end item malformed");

  a_emit_has_word: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEP || state == S_WORD) |-> (word_count != '0))
    else $error("emitting with empty word");

  a_busy_after_close: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_text |=> in_stall)
    else $error("end of text not followed by emission");
`endif

endmodule

@@ verif/greedy_word_wrap_stream_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_word_wrap_stream_unit_tb
// Self-checking bench for the greedy word wrap stream unit.
// ----------------------------------------------------------------------------
// Text bytes are fed through a queued driver with random gaps while the
// output side stalls at random. Each accepted byte is run through a local
// wrap predictor and every output word is compared field by field against
// the queued predictions. Line widths 80 (reset), 3, 1, 255, 0 and others
// are exercised, with a long output hold and a full drain along the way.
// ----------------------------------------------------------------------------
module greedy_word_wrap_stream_unit_tb;
  import gwws_pkg::*;

  localparam int WORD_MAX       = 32;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 50;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_char;
    logic       trunc;
    logic       done;
    logic       last;
  } wrap_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] text_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       is_char;
  logic       word_truncated;
  logic       text_done;
  logic       run_last;

  greedy_word_wrap_stream_unit #(.WORD_MAX(WORD_MAX)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .text_byte     (text_byte),
    .end_of_text   (end_of_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .is_char       (is_char),
    .word_truncated(word_truncated),
    .text_done     (text_done),
    .run_last      (run_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // wrap predictor state
  logic [7:0]  word_buf [WORD_MAX];
  int unsigned word_len  = 0;
  int unsigned line_len  = 0;
  bit          word_cut  = 1'b0;
  logic [7:0]  line_width = LINE_WIDTH_RESET;

  text_item_t  text_backlog [$];
  wrap_out_t   wrap_due [$];

  bit          in_took     = 1'b0;
  bit          hold_req    = 1'b0;
  int          hold_left   = 0;
  int          stall_left  = 0;
  int          send_gap    = 0;
  int unsigned cycle_no    = 0;
  int          idle_cycles = 0;
  int          errors      = 0;
  int          items_sent  = 0;
  int          phase_items = 0;
  int          texts_done  = 0;
  int          chars_seen  = 0;
  int          ends_seen   = 0;
  int          widths_used = 1;

  function automatic bit is_ws(input logic [7:0] b);
    return (b == SPACE_BYTE) || (b >= TAB_BYTE && b <= CR_BYTE);
  endfunction

  function automatic wrap_out_t mk_out(input logic [7:0] c, input logic ch,
                                       input logic t, input logic d);
    wrap_out_t w;
    w.ch = c;
    w.is_char = ch;
    w.trunc = t;
    w.done = d;
    w.last = 1'b0;
    return w;
  endfunction

  // mostly short gaps, a few long ones, none at all in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((cycle_no / 256) % 4 == 0) return 0;
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic close_word(ref wrap_out_t run_q[$]);
    if (word_len == 0) return;
    if (line_len == 0) begin
      line_len = word_len;
    end else if (line_len + 1 + word_len <= line_width) begin
      run_q = {run_q, mk_out(SPACE_BYTE, 1'b1, word_cut, 1'b0)};
      line_len = line_len + 1 + word_len;
    end else begin
      run_q = {run_q, mk_out(NEWLINE_BYTE, 1'b1, word_cut, 1'b0)};
      line_len = word_len;
    end
    for (int i = 0; i < word_len; i++)
      run_q = {run_q, mk_out(word_buf[i], 1'b1, word_cut, 1'b0)};
    line_len = line_len & 32'hFF;
    word_len = 0;
    word_cut = 1'b0;
  endtask

  task automatic wrap_byte(input logic [7:0] b, input logic eot);
    wrap_out_t run_q[$];
    if (is_ws(b)) begin
      close_word(run_q);
    end else if (word_len < WORD_MAX) begin
      word_buf[word_len] = b;
      word_len++;
    end else begin
      word_cut = 1'b1;
    end
    if (eot) begin
      close_word(run_q);
      run_q = {run_q, mk_out(8'h00, 1'b0, 1'b0, 1'b1)};
      word_len = 0;
      line_len = 0;
      word_cut = 1'b0;
      texts_done++;
    end
    if (run_q.size() > 0) run_q[$].last = 1'b1;
    wrap_due = {wrap_due, run_q};
  endtask

  task automatic check_word();
    wrap_out_t want;
    if (wrap_due.size() == 0) begin
      $error("unexpected word: out_byte %h is_char %b text_done %b",
             out_byte, is_char, text_done);
      errors++;
      return;
    end
    want = wrap_due.pop_front();
    if (out_byte !== want.ch) begin
      $error("out_byte: expected %h, got %h", want.ch, out_byte);
      errors++;
    end
    if (is_char !== want.is_char) begin
      $error("is_char: expected %b, got %b", want.is_char, is_char);
      errors++;
    end
    if (word_truncated !== want.trunc) begin
      $error("word_truncated: expected %b, got %b", want.trunc, word_truncated);
      errors++;
    end
    if (text_done !== want.done) begin
      $error("text_done: expected %b, got %b", want.done, text_done);
      errors++;
    end
    if (run_last !== want.last) begin
      $error("run_last: expected %b, got %b", want.last, run_last);
      errors++;
    end
    if (want.done) ends_seen++;
    else chars_seen++;
  endtask

  // monitor: prediction on input acceptance, checking on output acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_took = 1'b0;
      idle_cycles = 0;
    end else begin
      cycle_no++;
      in_took = in_valid && !in_stall;
      if (in_took) wrap_byte(text_byte, end_of_text);
      if (out_valid && !out_stall) check_word();
      if (in_took || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", idle_cycles);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    text_item_t nxt;
    if (!rst && (!in_valid || in_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (text_backlog.size() > 0) begin
        nxt = text_backlog.pop_front();
        text_byte <= nxt.b;
        end_of_text <= nxt.eot;
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic push_item(input logic [7:0] b, input logic eot);
    text_item_t it;
    it.b = b;
    it.eot = eot;
    text_backlog = {text_backlog, it};
    items_sent++;
    phase_items++;
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_ws(b));
    return b;
  endfunction

  function automatic logic [7:0] ws_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? SPACE_BYTE : TAB_BYTE + k[7:0];
  endfunction

  function automatic int pick_word_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 92) return $urandom_range(9, 20);
    if (r < 97) return $urandom_range(21, 32);
    return $urandom_range(33, 40);
  endfunction

  // one text ending in end_of_text: well formed mostly, raw noise sometimes
  task automatic queue_text(input bit force_long);
    int n_words;
    int len;
    int pushed;
    bit trail_ws;
    pushed = 0;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        push_item(8'($urandom_range(0, 255)), 1'b0);
        pushed++;
      end
    end else begin
      n_words = $urandom_range(0, 12);
      trail_ws = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 3) == 0) begin
        push_item(ws_char(), 1'b0);
        pushed++;
      end
      for (int w = 0; w < n_words; w++) begin
        len = (force_long && w == 0) ? $urandom_range(33, 40) : pick_word_len();
        for (int i = 0; i < len; i++) push_item(word_char(), 1'b0);
        pushed += len;
        if (w < n_words - 1 || trail_ws) begin
          repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1) begin
            push_item(ws_char(), 1'b0);
            pushed++;
          end
        end
      end
    end
    if (pushed == 0) push_item(ws_char(), 1'b0);
    text_backlog[$].eot = 1'b1;
  endtask

  task automatic wait_drained();
    while (text_backlog.size() > 0 || wrap_due.size() > 0 || in_valid) begin
      @(posedge clk);
      #2;
    end
  endtask

  task automatic drain_and_settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    #2;
  endtask

  task automatic set_width(input logic [7:0] w);
    @(negedge clk);
    cfg_data <= w;
    cfg_write <= 1'b1;
    @(negedge clk);
    cfg_write <= 1'b0;
    line_width = w;
    widths_used++;
    @(posedge clk);
    #2;
  endtask

  initial begin
    logic [7:0] widths [6];
    widths[0] = 8'd1;
    widths[1] = 8'd255;
    widths[2] = 8'd0;
    widths[3] = 8'd9;
    widths[4] = 8'($urandom_range(2, 254));
    widths[5] = 8'd40;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    #2;

    // reset width: whitespace-only texts, word closed by end of text,
    // field extremes and bytes either side of the whitespace range
    push_item(SPACE_BYTE, 1'b1);
    push_item(TAB_BYTE, 1'b0);  push_item(CR_BYTE, 1'b1);
    push_item(8'h41, 1'b1);
    push_item(8'h00, 1'b0);  push_item(8'hFF, 1'b0);  push_item(8'h0B, 1'b0);
    push_item(8'h08, 1'b0);  push_item(8'h0E, 1'b0);  push_item(8'h0C, 1'b0);
    push_item(8'h1F, 1'b0);  push_item(8'h21, 1'b0);  push_item(8'h7F, 1'b0);
    push_item(8'h80, 1'b0);  push_item(NEWLINE_BYTE, 1'b0);
    push_item(CR_BYTE, 1'b0);  push_item(8'h55, 1'b0);  push_item(8'hAA, 1'b1);
    drain_and_settle();

    // narrow line: exact fit, wrap, word wider than the line
    set_width(8'd3);
    push_item(8'h61, 1'b0);  push_item(SPACE_BYTE, 1'b0);  push_item(8'h62, 1'b0);
    push_item(SPACE_BYTE, 1'b0);  push_item(8'h63, 1'b0);  push_item(8'h64, 1'b0);
    push_item(8'h65, 1'b0);  push_item(8'h66, 1'b1);
    drain_and_settle();

    foreach (widths[p]) begin
      set_width(widths[p]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS / 2) queue_text(phase_items == 0);
      if (p == 1) begin
        hold_req = 1'b1;
      end else if (p == 3) begin
        wait_drained();
      end
      while (phase_items < PHASE_ITEMS) queue_text(1'b0);
      drain_and_settle();
    end

    $display("Sent %0d text bytes in %0d texts over %0d line widths, 0, 1 and 255 included.",
             items_sent, texts_done, widths_used);
    $display("Checked %0d characters and %0d end markers, with a long output hold.",
             chars_seen, ends_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
